FILE: rtl/plan_pkg.sv
// Shared types, widths and codes for the point/line attraction normal unit.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package plan_pkg;

	// Line direction, signed Q1.30
	localparam int AXIS_W    = 32;
	localparam int AXIS_FRAC = 30;

	// Normalized vector: largest magnitude lies in [2^30, 2^31]
	localparam int MAG_W    = 32;
	localparam int NORM_TOP = 31;
	localparam int SUM_W    = 2 * MAG_W;
	localparam int ROOT_W   = SUM_W / 2;

	// Quotient of one output component, magnitude at most 2^30
	localparam int QUO_W = 31;
	localparam int OUT_W = 32;

	// Vector width the line path needs
	localparam int LINE_VW = 36;

	// Bit-length scan
	localparam int SCAN_W = 64;
	localparam int LEN_W  = 7;

	// Attract modes
	localparam logic MODE_POINT = 1'b0;
	localparam logic MODE_LINE  = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE     = 3'd0,
		CFG_ANCHOR_X = 3'd1,
		CFG_ANCHOR_Y = 3'd2,
		CFG_ANCHOR_Z = 3'd3,
		CFG_AXIS_X   = 3'd4,
		CFG_AXIS_Y   = 3'd5,
		CFG_AXIS_Z   = 3'd6
	} cfg_idx_t;

	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef logic [2:0][AXIS_W-1:0] axis_vec_t;

	localparam axis_t AXIS_ONE     = 32'sh4000_0000;
	localparam axis_t AXIS_NEG_ONE = -AXIS_ONE;

	// Normalized magnitudes and their signs, handed down to root and divide
	typedef struct packed {
		logic                   zero;
		logic [2:0]             neg;
		logic [2:0][MAG_W-1:0]  mag;
	} norm_t;

	// Position of the highest set bit plus one, zero for zero
	function automatic logic [LEN_W-1:0] bit_len(input logic [SCAN_W-1:0] x);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < SCAN_W; i++) begin
			if (x[i]) begin
				n = LEN_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

FILE: rtl/plan_front.sv
// Front end: difference to the anchor, and in line mode the perpendicular
// toward the line. Eight pipeline stages. Depends on plan_pkg.
`timescale 1ns / 1ps

module plan_front #(
	parameter int CW = 32,
	parameter int VW = 36
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [2:0][CW-1:0]         pos,
	input  logic                       mode,
	input  logic [2:0][CW-1:0]         anchor,
	input  plan_pkg::axis_vec_t        axis,
	output logic                       out_valid,
	output logic [2:0][VW-1:0]         vec
);
	import plan_pkg::*;

	localparam int DW     = CW + 1;
	localparam int PROD_W = 2 * AXIS_W;
	localparam int DOT_W  = PROD_W - AXIS_FRAC;
	localparam int PQ_W   = AXIS_W + DOT_W;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6, mode_s7;

	logic signed [DW-1:0]     diff_s1 [3];
	logic signed [DW-1:0]     diff_s2 [3];
	logic signed [DW-1:0]     diff_s3 [3];
	logic signed [DW-1:0]     diff_s4 [3];
	logic signed [DW-1:0]     diff_s5 [3];
	logic signed [DW-1:0]     diff_s6 [3];
	logic signed [DW-1:0]     diff_s7 [3];
	logic [DW-1:0]            dor_c;
	logic [DW-1:0]            dor_s2;
	logic [LEN_W-1:0]         len_c;
	logic [LEN_W-1:0]         sh_s3;
	logic signed [AXIS_W-1:0] ds_s4 [3];
	logic signed [AXIS_W-1:0] ds_s5 [3];
	logic signed [AXIS_W-1:0] ds_s6 [3];
	logic signed [AXIS_W-1:0] ds_s7 [3];
	logic signed [PROD_W-1:0] prod_s5 [3];
	logic signed [PROD_W-1:0] dsum_c;
	logic signed [DOT_W-1:0]  dot_s6;
	logic signed [PQ_W-1:0]   pq_s7 [3];
	logic [2:0][VW-1:0]       vec_s8;

	// OR of the difference magnitudes gives the bit length of the largest
	always_comb begin
		dor_c = '0;
		for (int i = 0; i < 3; i++) begin
			dor_c = dor_c | (diff_s1[i][DW-1] ? $unsigned(-diff_s1[i]) : $unsigned(diff_s1[i]));
		end
	end

	assign len_c  = bit_len(SCAN_W'(dor_s2));
	assign dsum_c = prod_s5[0] + prod_s5[1] + prod_s5[2];

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			mode_s2 <= mode_s1;
			mode_s3 <= mode_s2;
			mode_s4 <= mode_s3;
			mode_s5 <= mode_s4;
			mode_s6 <= mode_s5;
			mode_s7 <= mode_s6;
			dor_s2  <= dor_c;
			sh_s3   <= (len_c > LEN_W'(NORM_TOP)) ? len_c - LEN_W'(NORM_TOP) : '0;
			dot_s6  <= DOT_W'(dsum_c >>> AXIS_FRAC);
			for (int i = 0; i < 3; i++) begin
				// exact difference, position minus anchor
				diff_s1[i] <= DW'($signed(pos[i])) - DW'($signed(anchor[i]));
				diff_s2[i] <= diff_s1[i];
				diff_s3[i] <= diff_s2[i];
				diff_s4[i] <= diff_s3[i];
				diff_s5[i] <= diff_s4[i];
				diff_s6[i] <= diff_s5[i];
				diff_s7[i] <= diff_s6[i];
				// floor shift into 32 bits for the line products
				ds_s4[i]   <= AXIS_W'(diff_s3[i] >>> sh_s3);
				ds_s5[i]   <= ds_s4[i];
				ds_s6[i]   <= ds_s5[i];
				ds_s7[i]   <= ds_s6[i];
				prod_s5[i] <= $signed(axis[i]) * ds_s4[i];
				pq_s7[i]   <= $signed(axis[i]) * dot_s6;
				// line: d*(d.diff) - diff, point: anchor - pos
				vec_s8[i]  <= (mode_s7 == MODE_LINE) ?
					VW'(pq_s7[i] >>> AXIS_FRAC) - VW'(ds_s7[i]) :
					-VW'(diff_s7[i]);
			end
		end
	end

	assign out_valid = vld_s8;
	assign vec       = vec_s8;

endmodule

FILE: rtl/plan_norm.sv
// Normalizer: scales the vector so its largest component has bit length 31,
// then forms the sum of squares. Six pipeline stages. Depends on plan_pkg.
`timescale 1ns / 1ps

module plan_norm #(
	parameter int VW = 36
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [2:0][VW-1:0]          vec,
	output logic                        out_valid,
	output logic [plan_pkg::SUM_W-1:0]  sum,
	output plan_pkg::norm_t             info
);
	import plan_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [VW-1:0]           vor_c;
	logic [VW-1:0]           vor_s1;
	logic signed [VW-1:0]    v_s1 [3];
	logic signed [VW-1:0]    v_s2 [3];
	logic [LEN_W-1:0]        len_s2;
	logic signed [MAG_W-1:0] w_c [3];
	logic signed [MAG_W-1:0] w_s3 [3];
	logic                    zero_s3, zero_s4, zero_s5;
	logic [MAG_W-1:0]        mag_s4 [3];
	logic [MAG_W-1:0]        mag_s5 [3];
	logic [2:0]              neg_s4, neg_s5;
	logic [SUM_W-1:0]        sq_s5 [3];
	logic [SUM_W-1:0]        sum_s6;
	norm_t                   info_s6;

	// OR of magnitudes for the bit length
	always_comb begin
		vor_c = '0;
		for (int i = 0; i < 3; i++) begin
			vor_c = vor_c | (vec[i][VW-1] ? VW'(-vec[i]) : vec[i]);
		end
	end

	// Shift left exactly or right with floor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (len_s2 > LEN_W'(NORM_TOP)) begin
				w_c[i] = MAG_W'(v_s2[i] >>> (len_s2 - LEN_W'(NORM_TOP)));
			end else begin
				w_c[i] = MAG_W'(v_s2[i] <<< (LEN_W'(NORM_TOP) - len_s2));
			end
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			vor_s1       <= vor_c;
			len_s2       <= bit_len(SCAN_W'(vor_s1));
			zero_s3      <= (len_s2 == '0);
			zero_s4      <= zero_s3;
			zero_s5      <= zero_s4;
			neg_s5       <= neg_s4;
			sum_s6       <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			info_s6.zero <= zero_s5;
			info_s6.neg  <= neg_s5;
			for (int i = 0; i < 3; i++) begin
				v_s1[i]        <= $signed(vec[i]);
				v_s2[i]        <= v_s1[i];
				w_s3[i]        <= w_c[i];
				neg_s4[i]      <= w_s3[i][MAG_W-1];
				mag_s4[i]      <= w_s3[i][MAG_W-1] ? MAG_W'(-w_s3[i]) : MAG_W'(w_s3[i]);
				mag_s5[i]      <= mag_s4[i];
				sq_s5[i]       <= SUM_W'(mag_s4[i]) * SUM_W'(mag_s4[i]);
				info_s6.mag[i] <= mag_s5[i];
			end
		end
	end

	assign out_valid = vld_s6;
	assign sum       = sum_s6;
	assign info      = info_s6;

endmodule

FILE: rtl/plan_sqrt.sv
// Floor square root of the 64-bit sum of squares, one root bit per stage
// over 32 stages. Carries the normalized magnitudes along. Depends on plan_pkg.
`timescale 1ns / 1ps

module plan_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [plan_pkg::SUM_W-1:0]   rad,
	input  plan_pkg::norm_t              info,
	output logic                         out_valid,
	output logic [plan_pkg::ROOT_W-1:0]  root,
	output plan_pkg::norm_t              info_out
);
	import plan_pkg::*;

	localparam int REM_W = ROOT_W + 3;

	logic                vld_s  [ROOT_W+1];
	logic [SUM_W-1:0]    rad_s  [ROOT_W+1];
	logic [REM_W-1:0]    rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0]   root_s [ROOT_W+1];
	norm_t               info_s [ROOT_W+1];

	// Stage zero is the incoming request
	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign info_s[0] = info;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [REM_W-1:0]  rem_x;
		logic [REM_W-1:0]  trial;
		logic [REM_W-1:0]  rem_n;
		logic [ROOT_W-1:0] root_n;

		// Bring down two radicand bits, try root*4+1
		always_comb begin
			rem_x = {rem_s[k][REM_W-3:0], rad_s[k][SUM_W-1 -: 2]};
			trial = REM_W'({root_s[k], 2'b01});
			if (rem_x >= trial) begin
				rem_n  = rem_x - trial;
				root_n = {root_s[k][ROOT_W-2:0], 1'b1};
			end else begin
				rem_n  = rem_x;
				root_n = {root_s[k][ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= rad_s[k] << 2;
				rem_s[k+1]  <= rem_n;
				root_s[k+1] <= root_n;
				info_s[k+1] <= info_s[k];
			end
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign info_out  = info_s[ROOT_W];

endmodule

FILE: rtl/plan_div.sv
// Three parallel restoring dividers: |v|*2^30 + n/2 over n, one quotient bit
// per stage, after one stage that forms the numerators. Depends on plan_pkg.
`timescale 1ns / 1ps

module plan_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [plan_pkg::ROOT_W-1:0]       root,
	input  plan_pkg::norm_t                   info,
	output logic                              out_valid,
	output logic [2:0][plan_pkg::QUO_W-1:0]   quo,
	output logic [2:0]                        neg,
	output logic                              zero
);
	import plan_pkg::*;

	localparam int NUM_W = MAG_W + AXIS_FRAC;
	localparam int REM_W = ROOT_W + 1;

	logic                     vld_s  [QUO_W+1];
	logic [ROOT_W-1:0]        den_s  [QUO_W+1];
	logic [2:0][REM_W-1:0]    rem_s  [QUO_W+1];
	logic [2:0][QUO_W-1:0]    low_s  [QUO_W+1];
	logic [2:0][QUO_W-1:0]    quo_s  [QUO_W+1];
	logic [2:0]               neg_s  [QUO_W+1];
	logic                     zero_s [QUO_W+1];
	logic [NUM_W-1:0]         num_c  [3];

	// Numerator with half the divisor added for rounding
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = (NUM_W'(info.mag[i]) << AXIS_FRAC) + NUM_W'(root >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	// Load the dividers: the top bits already lie below the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= root;
			neg_s[0]  <= info.neg;
			zero_s[0] <= info.zero;
			quo_s[0]  <= '0;
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= REM_W'(num_c[i][NUM_W-1:QUO_W]);
				low_s[0][i] <= num_c[i][QUO_W-1:0];
			end
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [2:0][REM_W-1:0] rem_x;
		logic [2:0][REM_W-1:0] rem_n;
		logic [2:0]            qbit;

		// Shift in the next numerator bit, subtract when it fits
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem_x[i] = {rem_s[k][i][REM_W-2:0], low_s[k][i][QUO_W-1]};
				if (rem_x[i] >= REM_W'(den_s[k])) begin
					rem_n[i] = rem_x[i] - REM_W'(den_s[k]);
					qbit[i]  = 1'b1;
				end else begin
					rem_n[i] = rem_x[i];
					qbit[i]  = 1'b0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				neg_s[k+1]  <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
				rem_s[k+1]  <= rem_n;
				for (int i = 0; i < 3; i++) begin
					low_s[k+1][i] <= low_s[k][i] << 1;
					quo_s[k+1][i] <= {quo_s[k][i][QUO_W-2:0], qbit[i]};
				end
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign quo       = quo_s[QUO_W];
	assign neg       = neg_s[QUO_W];
	assign zero      = zero_s[QUO_W];

endmodule

FILE: rtl/point_line_attract_normal_unit.sv
// 79 register stages from the request inputs through the output register.
// One request per cycle unless stalled; the 32-stage root and 32-stage divider set the depth.
// A stalled output freezes the whole pipeline; requests are taken whenever it moves.
// Reset clears all valid bits and loads mode point, anchor 0 and axis (1, 0, 0).
// Top level: configuration registers, pipeline glue and output register.
// Depends on plan_pkg, plan_front, plan_norm, plan_sqrt and plan_div.
`timescale 1ns / 1ps

module point_line_attract_normal_unit #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [COORD_WIDTH-1:0]          pos_x,
	input  logic signed [COORD_WIDTH-1:0]          pos_y,
	input  logic signed [COORD_WIDTH-1:0]          pos_z,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [plan_pkg::OUT_W-1:0]      dir_out_x,
	output logic signed [plan_pkg::OUT_W-1:0]      dir_out_y,
	output logic signed [plan_pkg::OUT_W-1:0]      dir_out_z,
	output logic                                   zero_length,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [plan_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] cfg_data
);
	import plan_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int VW = (CW + 1 > LINE_VW) ? CW + 1 : LINE_VW;

	logic                   mode_q;
	logic [2:0][CW-1:0]     anchor_q;
	axis_vec_t              axis_q;
	axis_t                  axis_c;
	logic                   en;

	logic                   fr_valid;
	logic [2:0][VW-1:0]     fr_vec;
	logic                   nm_valid;
	logic [SUM_W-1:0]       nm_sum;
	norm_t                  nm_info;
	logic                   sq_valid;
	logic [ROOT_W-1:0]      sq_root;
	norm_t                  sq_info;
	logic                   dv_valid;
	logic [2:0][QUO_W-1:0]  dv_quo;
	logic [2:0]             dv_neg;
	logic                   dv_zero;

	logic                   out_valid_q;
	logic [2:0][OUT_W-1:0]  dir_q;
	logic                   zero_q;

	// Pipeline moves unless a result sits stalled at the output
	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Saturate the line direction to [-1, 1]
	always_comb begin
		axis_c = $signed(cfg_data[AXIS_W-1:0]);
		if ($signed(cfg_data[AXIS_W-1:0]) > AXIS_ONE) begin
			axis_c = AXIS_ONE;
		end else if ($signed(cfg_data[AXIS_W-1:0]) < AXIS_NEG_ONE) begin
			axis_c = AXIS_NEG_ONE;
		end
	end

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_POINT;
			anchor_q  <= '0;
			axis_q[0] <= AXIS_ONE;
			axis_q[1] <= '0;
			axis_q[2] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:     mode_q      <= cfg_data[0];
				CFG_ANCHOR_X: anchor_q[0] <= cfg_data[CW-1:0];
				CFG_ANCHOR_Y: anchor_q[1] <= cfg_data[CW-1:0];
				CFG_ANCHOR_Z: anchor_q[2] <= cfg_data[CW-1:0];
				CFG_AXIS_X:   axis_q[0]   <= axis_c;
				CFG_AXIS_Y:   axis_q[1]   <= axis_c;
				CFG_AXIS_Z:   axis_q[2]   <= axis_c;
				default: ;
			endcase
		end
	end

	plan_front #(
		.CW (CW),
		.VW (VW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.pos       ({pos_z, pos_y, pos_x}),
		.mode      (mode_q),
		.anchor    (anchor_q),
		.axis      (axis_q),
		.out_valid (fr_valid),
		.vec       (fr_vec)
	);

	plan_norm #(
		.VW (VW)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.vec       (fr_vec),
		.out_valid (nm_valid),
		.sum       (nm_sum),
		.info      (nm_info)
	);

	plan_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (nm_valid),
		.rad       (nm_sum),
		.info      (nm_info),
		.out_valid (sq_valid),
		.root      (sq_root),
		.info_out  (sq_info)
	);

	plan_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.root      (sq_root),
		.info      (sq_info),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.neg       (dv_neg),
		.zero      (dv_zero)
	);

	// Output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	// Output register: apply signs, force zero for a zero-length vector
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= dv_zero;
			for (int i = 0; i < 3; i++) begin
				if (dv_zero) begin
					dir_q[i] <= '0;
				end else if (dv_neg[i]) begin
					dir_q[i] <= -OUT_W'(dv_quo[i]);
				end else begin
					dir_q[i] <= OUT_W'(dv_quo[i]);
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign dir_out_x   = $signed(dir_q[0]);
	assign dir_out_y   = $signed(dir_q[1]);
	assign dir_out_z   = $signed(dir_q[2]);
	assign zero_length = zero_q;

endmodule

FILE: rtl/plan_checker.sv
// Port-level checks on the result channel of the attraction normal unit,
// bound to the top level. Depends on plan_pkg.
`timescale 1ns / 1ps

module plan_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [plan_pkg::OUT_W-1:0]  dir_out_x,
	input logic signed [plan_pkg::OUT_W-1:0]  dir_out_y,
	input logic signed [plan_pkg::OUT_W-1:0]  dir_out_z,
	input logic                               zero_length
);
	localparam logic signed [31:0] Q_ONE  = 32'sh4000_0000;
	localparam logic signed [31:0] Q_HALF = 32'sh2000_0000;

	// A stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(dir_out_x) && $stable(dir_out_y)
			&& $stable(dir_out_z) && $stable(zero_length))
		else $error("result changed while stalled");

	// A zero-length flag comes with the zero vector
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> dir_out_x == '0 && dir_out_y == '0 && dir_out_z == '0)
		else $error("zero_length with a nonzero vector");

	// Every component lies within [-1, 1]
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dir_out_x <= Q_ONE && dir_out_x >= -Q_ONE
			&& dir_out_y <= Q_ONE && dir_out_y >= -Q_ONE
			&& dir_out_z <= Q_ONE && dir_out_z >= -Q_ONE)
		else $error("component out of unit range");

	// A unit vector has some component of magnitude at least one half
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_length |->
			dir_out_x >= Q_HALF || dir_out_x <= -Q_HALF
			|| dir_out_y >= Q_HALF || dir_out_y <= -Q_HALF
			|| dir_out_z >= Q_HALF || dir_out_z <= -Q_HALF)
		else $error("result is not normalized");

endmodule

bind point_line_attract_normal_unit plan_checker u_plan_checker (.*);
